>>> rtl/medh_pkg.sv
// ----------------------------------------------------------------------------
// medh_pkg
// Shared constants, types and helpers for the two-sorted-sequence median core.
// ----------------------------------------------------------------------------
package medh_pkg;

  localparam int MAX_LEN = 1024;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = 11;
  localparam int DATA_W  = 32;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic cfg_wr;
    logic load;
    logic read;
    logic step;
    logic emit;
  } medh_cmd_t;

  typedef struct packed {
    logic full;
    logic found;
    logic out_free;
  } medh_sts_t;

  // zero acts as one, anything above the store depth saturates
  function automatic cnt_t eff_len(input cnt_t v);
    cnt_t r;
    if (v == '0) begin
      r = cnt_t'(1);
    end else if (v > cnt_t'(MAX_LEN)) begin
      r = cnt_t'(MAX_LEN);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/median_of_two_sorted_halving_core.sv
// ----------------------------------------------------------------------------
// median_of_two_sorted_halving_core
// Lower median of two equal-length ascending signed sequences.
// ----------------------------------------------------------------------------
// Elements are loaded one per cycle while in_stall_o is low, each request
// tagged for the first or the second sequence; requests beyond the programmed
// length are dropped. The request that completes both sequences starts a
// halving search; each step is one store read and one compare, and there are
// fewer steps when the middles tie. in_stall_o is high during the search. The
// search holds in its last step while the previous result is still stalled
// in the output register. Once the result is registered, loading of the next
// pair may begin while it waits to be taken. seq_length is written through
// the cfg channel while the core is idle; 0 acts as 1 and values above 1024
// saturate.
module median_of_two_sorted_halving_core
  import medh_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CNT_W-1:0]         cfg_seq_length_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     seq_select_i,
  input  logic signed [DATA_W-1:0] elem_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] median_value_o
);

  medh_cmd_t cmd;
  medh_sts_t sts;

  medh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cfg_valid_i (cfg_valid_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .cfg_ready_o (cfg_ready_o)
  );

  medh_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_seq_length_i (cfg_seq_length_i),
    .seq_select_i     (seq_select_i),
    .elem_value_i     (elem_value_i),
    .median_value_o   (median_value_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i)
  );

endmodule

>>> rtl/medh_ctrl.sv
// ----------------------------------------------------------------------------
// medh_ctrl
// Sequencer: load phase, then alternating memory read and compare steps.
// ----------------------------------------------------------------------------
module medh_ctrl
  import medh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      cfg_valid_i,
  input  medh_sts_t sts_i,
  output medh_cmd_t cmd_o,
  output logic      in_stall_o,
  output logic      cfg_ready_o
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_READ,
    S_CMP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_stall_o   = 1'b0;
        cfg_ready_o  = 1'b1;
        cmd_o.cfg_wr = cfg_valid_i;
        cmd_o.load   = in_valid_i;
        if (in_valid_i && sts_i.full) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_CMP;
      end
      S_CMP: begin
        if (!sts_i.found) begin
          cmd_o.step = 1'b1;
          state_d    = S_READ;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/medh_dp.sv
// ----------------------------------------------------------------------------
// medh_dp
// Element stores, load counters, search windows and the result register.
// ----------------------------------------------------------------------------
module medh_dp
  import medh_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  medh_cmd_t                cmd_i,
  output medh_sts_t                sts_o,
  input  logic [CNT_W-1:0]         cfg_seq_length_i,
  input  logic                     seq_select_i,
  input  logic signed [DATA_W-1:0] elem_value_i,
  output logic signed [DATA_W-1:0] median_value_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i
);

  logic signed [DATA_W-1:0] mem_a [MAX_LEN];
  logic signed [DATA_W-1:0] mem_b [MAX_LEN];
  logic signed [DATA_W-1:0] rd_a_q, rd_b_q;
  logic signed [DATA_W-1:0] median_q, result;

  cnt_t  n_q, cnt_a_q, cnt_b_q, cnt_a_nx, cnt_b_nx;
  addr_t lo_a_q, hi_a_q, lo_b_q, hi_b_q, mid_a, mid_b, n_m1;
  logic [ADDR_W:0] sum_a, sum_b;
  logic wr_a, wr_b, odd_win, single, a_lt_b, out_valid_q;

  assign wr_a     = cmd_i.load && !seq_select_i && (cnt_a_q < n_q);
  assign wr_b     = cmd_i.load &&  seq_select_i && (cnt_b_q < n_q);
  assign cnt_a_nx = wr_a ? cnt_a_q + cnt_t'(1) : cnt_a_q;
  assign cnt_b_nx = wr_b ? cnt_b_q + cnt_t'(1) : cnt_b_q;
  assign n_m1     = addr_t'(n_q - cnt_t'(1));

  assign sum_a   = {1'b0, lo_a_q} + {1'b0, hi_a_q};
  assign sum_b   = {1'b0, lo_b_q} + {1'b0, hi_b_q};
  assign mid_a   = sum_a[ADDR_W:1];
  assign mid_b   = sum_b[ADDR_W:1];
  assign odd_win = !sum_a[0];
  assign single  = (lo_a_q == hi_a_q) && (lo_b_q == hi_b_q);
  assign a_lt_b  = rd_a_q < rd_b_q;
  assign result  = (single && !a_lt_b) ? rd_b_q : rd_a_q;

  assign sts_o.full     = (cnt_a_nx >= n_q) && (cnt_b_nx >= n_q);
  assign sts_o.found    = single || (rd_a_q == rd_b_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign median_value_o = median_q;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[cnt_a_q[ADDR_W-1:0]] <= elem_value_i;
    end
    if (wr_b) begin
      mem_b[cnt_b_q[ADDR_W-1:0]] <= elem_value_i;
    end
    if (cmd_i.read) begin
      rd_a_q <= mem_a[mid_a];
      rd_b_q <= mem_b[mid_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && sts_o.full) begin
      lo_a_q <= '0;
      lo_b_q <= '0;
      hi_a_q <= n_m1;
      hi_b_q <= n_m1;
    end else if (cmd_i.step) begin
      if (a_lt_b) begin
        lo_a_q <= odd_win ? mid_a : mid_a + addr_t'(1);
        hi_b_q <= mid_b;
      end else begin
        lo_b_q <= odd_win ? mid_b : mid_b + addr_t'(1);
        hi_a_q <= mid_a;
      end
    end
    if (cmd_i.emit) begin
      median_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= cnt_t'(1);
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cfg_wr) begin
        n_q <= eff_len(cfg_seq_length_i);
      end
      if (cmd_i.load) begin
        if (sts_o.full) begin
          cnt_a_q <= '0;
          cnt_b_q <= '0;
        end else begin
          cnt_a_q <= cnt_a_nx;
          cnt_b_q <= cnt_b_nx;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/medh_chk.sv
// ----------------------------------------------------------------------------
// medh_chk
// Port-level checks for the median core, bound to the top level.
// ----------------------------------------------------------------------------
module medh_chk
  import medh_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     cfg_ready_o,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DATA_W-1:0] median_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(median_value_o))
    else $error("stalled result changed");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o == !in_stall_o)
    else $error("cfg ready outside load phase");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("search started without a request");

  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result outside search");

endmodule

bind median_of_two_sorted_halving_core medh_chk u_medh_chk (.*);

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-sorted-sequence lower median core.
// ----------------------------------------------------------------------------
// A short table of directed requests covers the value extremes, length zero,
// dropped extra elements, ties and a length lowered while a pair is half
// loaded. Random pairs of sorted sequences follow, with some unsorted pairs
// and extra elements mixed in, and the length is rewritten between pairs.
// A behavioral model of the halving search predicts each median that the
// table does not give. Every median leaving the core is compared with the
// oldest prediction, under four mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import medh_pkg::*;

  localparam int SETTLE = 40;
  localparam int LIMIT  = 400000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CNT_W-1:0]         cfg_seq_length_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     seq_select_i = 1'b0;
  logic signed [DATA_W-1:0] elem_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] median_value_o;

  median_of_two_sorted_halving_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_seq_length_i (cfg_seq_length_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .seq_select_i     (seq_select_i),
    .elem_value_i     (elem_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .median_value_o   (median_value_o)
  );

  typedef struct {
    bit        wr;
    bit [10:0] len;
    bit        sel;
    int        val;
    bit        known;
    int        res;
  } req_row_t;

  // wr: write len (core idle) before the request
  req_row_t dir_rows [24] = '{
    '{1'b0, 11'd0, 1'b0, 32'sh7FFF_FFFF, 1'b0, 0},
    '{1'b0, 11'd0, 1'b1, 32'sh8000_0000, 1'b1, 32'sh8000_0000},
    '{1'b0, 11'd0, 1'b1, -1,             1'b0, 0},
    '{1'b0, 11'd0, 1'b0, 0,              1'b1, -1},
    '{1'b0, 11'd0, 1'b0, 5,              1'b0, 0},
    '{1'b0, 11'd0, 1'b0, 9,              1'b0, 0},
    '{1'b0, 11'd0, 1'b1, 5,              1'b1, 5},
    '{1'b1, 11'd0, 1'b1, 7,              1'b0, 0},
    '{1'b0, 11'd0, 1'b0, 3,              1'b1, 3},
    '{1'b1, 11'd2, 1'b0, 10,             1'b0, 0},
    '{1'b0, 11'd0, 1'b0, 20,             1'b0, 0},
    '{1'b0, 11'd0, 1'b1, 15,             1'b0, 0},
    '{1'b0, 11'd0, 1'b1, 25,             1'b1, 15},
    '{1'b1, 11'd3, 1'b0, 1,              1'b0, 0},
    '{1'b0, 11'd0, 1'b0, 2,              1'b0, 0},
    '{1'b0, 11'd0, 1'b0, 3,              1'b0, 0},
    '{1'b0, 11'd0, 1'b1, 4,              1'b0, 0},
    '{1'b0, 11'd0, 1'b1, 5,              1'b0, 0},
    '{1'b0, 11'd0, 1'b1, 6,              1'b1, 3},
    '{1'b1, 11'd4, 1'b0, -8,             1'b0, 0},
    '{1'b0, 11'd0, 1'b0, -4,             1'b0, 0},
    '{1'b0, 11'd0, 1'b0, 0,              1'b0, 0},
    '{1'b0, 11'd0, 1'b1, -6,             1'b0, 0},
    '{1'b1, 11'd2, 1'b1, 100,            1'b0, 0}
  };

  // model state
  logic signed [DATA_W-1:0] first_mem  [MAX_LEN];
  logic signed [DATA_W-1:0] second_mem [MAX_LEN];
  int                       first_cnt;
  int                       second_cnt;
  logic [CNT_W-1:0]         len_reg;

  logic signed [DATA_W-1:0] pending_medians [$];
  logic signed [DATA_W-1:0] want;

  int gap_pct;
  int stall_pct;
  int cycle_cnt;
  int fail_cnt;
  int checked_medians;
  int elems_sent;
  int elems_dropped;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_medians.size() == 0) begin
        $error("median_value: expected none, actual %0d", median_value_o);
        fail_cnt++;
      end else begin
        want = pending_medians.pop_front();
        if (median_value_o !== want) begin
          $error("median_value: expected %0d, actual %0d", want, median_value_o);
          fail_cnt++;
        end
        checked_medians++;
      end
    end
  end

  function automatic int active_length();
    if (len_reg == '0) return 1;
    if (len_reg > CNT_W'(MAX_LEN)) return MAX_LEN;
    return int'(len_reg);
  endfunction

  // halving search over the first n entries of both stores
  function automatic logic signed [DATA_W-1:0] halving_median(int n);
    int lo_a, hi_a, lo_b, hi_b, mid_a, mid_b;
    bit odd_win;
    lo_a = 0;
    hi_a = n - 1;
    lo_b = 0;
    hi_b = n - 1;
    while (lo_a != hi_a || lo_b != hi_b) begin
      mid_a   = (lo_a + hi_a) >> 1;
      mid_b   = (lo_b + hi_b) >> 1;
      odd_win = ((lo_a + hi_a) % 2) == 0;
      if (first_mem[mid_a] == second_mem[mid_b]) return first_mem[mid_a];
      if (first_mem[mid_a] < second_mem[mid_b]) begin
        lo_a = odd_win ? mid_a : mid_a + 1;
        hi_b = mid_b;
      end else begin
        lo_b = odd_win ? mid_b : mid_b + 1;
        hi_a = mid_a;
      end
    end
    return (first_mem[lo_a] < second_mem[lo_b]) ? first_mem[lo_a] : second_mem[lo_b];
  endfunction

  function automatic bit load_element(input bit sel, input logic signed [DATA_W-1:0] v,
                                      output logic signed [DATA_W-1:0] med);
    int n;
    n   = active_length();
    med = '0;
    if (!sel && first_cnt < n) begin
      first_mem[first_cnt] = v;
      first_cnt++;
    end else if (sel && second_cnt < n) begin
      second_mem[second_cnt] = v;
      second_cnt++;
    end else begin
      elems_dropped++;
    end
    if (first_cnt >= n && second_cnt >= n) begin
      med        = halving_median(n);
      first_cnt  = 0;
      second_cnt = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic set_idling(input int mix);
    case (mix)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 62; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 62; end
      default: begin gap_pct = 14; stall_pct = 14; end
    endcase
  endtask

  task automatic send_element(input bit sel, input logic signed [DATA_W-1:0] v,
                              output bit has_med, output logic signed [DATA_W-1:0] med);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    seq_select_i <= sel;
    elem_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    elems_sent++;
    has_med = load_element(sel, v, med);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [CNT_W-1:0] v);
    cfg_seq_length_i <= v;
    cfg_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    len_reg      = v;
  endtask

  task automatic make_seq(output int q[$], input int n, input int style, input bit ordered);
    q = {};
    repeat (n) begin
      case (style)
        0: q.push_back(int'($urandom));
        1: q.push_back(int'($urandom_range(8)) - 4);
        default: q.push_back(int'($urandom) >>> $urandom_range(31));
      endcase
    end
    if (ordered) q.sort();
  endtask

  // interleaves two sequences; with extras, a full side gets dropped requests
  task automatic load_pair(input int a[$], input int b[$], input bit extras);
    int ia, ib;
    bit pick, has_med;
    logic signed [DATA_W-1:0] med;
    ia = 0;
    ib = 0;
    while (ia < a.size() || ib < b.size()) begin
      if (extras && $urandom_range(5) == 0 && ((ia == a.size()) != (ib == b.size()))) begin
        send_element(ib == b.size(), $urandom, has_med, med);
      end else begin
        if (ia == a.size()) pick = 1'b1;
        else if (ib == b.size()) pick = 1'b0;
        else pick = $urandom_range(1);
        if (!pick) begin
          send_element(1'b0, a[ia], has_med, med);
          ia++;
        end else begin
          send_element(1'b1, b[ib], has_med, med);
          ib++;
        end
      end
      if (has_med) pending_medians.push_back(med);
    end
  endtask

  initial begin
    int a_seq[$], b_seq[$];
    int pairs, sent_base, med_base, r;
    bit has_med;
    logic signed [DATA_W-1:0] med;
    logic [CNT_W-1:0] pick_len;

    first_cnt  = 0;
    second_cnt = 0;
    len_reg    = CNT_W'(1);
    set_idling(0);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(3);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) begin
        drain();
        write_length(dir_rows[i].len);
      end
      send_element(dir_rows[i].sel, dir_rows[i].val, has_med, med);
      if (has_med) pending_medians.push_back(dir_rows[i].known ? dir_rows[i].res : med);
    end

    pairs     = 0;
    sent_base = elems_sent;
    med_base  = checked_medians + pending_medians.size();
    while (elems_sent - sent_base < 420 ||
           checked_medians + pending_medians.size() - med_base < 40) begin
      if (pairs % 4 == 0) set_idling((pairs / 4) % 4);
      if ($urandom_range(3) == 0 || pairs % 10 == 9) begin
        drain();
        r = $urandom_range(15);
        if (r == 0) pick_len = '0;
        else if (r == 1) pick_len = CNT_W'($urandom_range(9, 40));
        else pick_len = CNT_W'($urandom_range(1, 8));
        write_length(pick_len);
      end
      r = $urandom_range(2);
      make_seq(a_seq, active_length(), r, $urandom_range(9) != 0);
      make_seq(b_seq, active_length(), r, $urandom_range(9) != 0);
      load_pair(a_seq, b_seq, $urandom_range(4) == 0);
      pairs++;
    end

    drain();

    if (pending_medians.size() != 0) fail_cnt++;
    $display("Sent %0d elements (%0d dropped as extras), checked %0d medians,",
             elems_sent, elems_dropped, checked_medians);
    $display("lengths 0 to 40, ties, unsorted pairs, a length lowered mid-pair, four idle mixes.");
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
